// ===== sv/sarena_pkg.sv =====
// Shared types and constants for the stack arena allocator.
package sarena_pkg;

   localparam int MAX_TRACKED = 64;
   localparam int ADDR_W      = 32;
   localparam int STK_IDX_W   = $clog2(MAX_TRACKED);
   localparam int STK_CNT_W   = $clog2(MAX_TRACKED + 1);
   localparam int LIVE_W      = 7;
   localparam int TRACK_W     = 7;
   localparam int ALIGN_W     = 5;
   localparam int MAX_ALIGN   = 16;
   localparam int AMASK_W     = MAX_ALIGN;
   localparam int CSR_IDX_W   = 2;

   // one past the last byte of the address space
   localparam logic [ADDR_W+2:0] ADDR_SPAN = {3'b001, {ADDR_W{1'b0}}};

   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_FREE   = 2'd1;
   localparam logic [1:0] REQ_RESIZE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_LIMIT = 2'd2;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_SPACE   = 3'd1,
      ST_OUTSIDE    = 3'd2,
      ST_ABOVE_TOP  = 3'd3,
      ST_ORDER      = 3'd4,
      ST_BAD_REQ    = 3'd5,
      ST_TRACK_FULL = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_BAD
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_COMMIT
   } bk_state_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [ADDR_W-1:0]  addr;
      logic [ADDR_W-1:0]  size;
      logic [ALIGN_W-1:0] align_log2;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  result_addr;
      logic [ADDR_W-1:0]  used_bytes;
      logic [ADDR_W-1:0]  peak_bytes;
      logic [LIVE_W-1:0]  live_count;
   } rsp_word_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [ADDR_W-1:0]  addr;
      logic [AMASK_W-1:0] amask;
      logic [ADDR_W:0]    asize;
   } cmd_word_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [ADDR_W-1:0] push_data;
   } stk_ctl_type;

   typedef struct packed {
      logic [STK_CNT_W-1:0] count;
      logic [ADDR_W-1:0]    exp_off;
   } stk_stat_type;

endpackage

// ===== sv/sarena_front.sv =====
// Request intake: decode, alignment mask and size rounding, two-entry command queue.
module sarena_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  sarena_pkg::req_word_type  req_data,
   output logic                      cmd_valid,
   input  logic                      cmd_pop,
   output sarena_pkg::cmd_word_type  cmd_data
);

   logic [sarena_pkg::AMASK_W:0]   amask_wide;
   logic [sarena_pkg::AMASK_W-1:0] amask;
   logic [sarena_pkg::ADDR_W:0]    amask_ext;
   sarena_pkg::cmd_word_type       cmd_new;

   sarena_pkg::cmd_word_type q_ff [2];
   logic                     wr_ptr_ff, wr_ptr_in;
   logic                     rd_ptr_ff, rd_ptr_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic                     do_push, do_pop;

   always_comb begin
      amask_wide = ((sarena_pkg::AMASK_W + 1)'(1) << req_data.align_log2)
                   - (sarena_pkg::AMASK_W + 1)'(1);
      amask      = amask_wide[sarena_pkg::AMASK_W-1:0];
      amask_ext  = (sarena_pkg::ADDR_W + 1)'(amask);

      cmd_new.addr  = req_data.addr;
      cmd_new.amask = amask;
      cmd_new.asize = ((sarena_pkg::ADDR_W + 1)'(req_data.size) + amask_ext) & ~amask_ext;

      case (req_data.req_type)
         sarena_pkg::REQ_ALLOC: begin
            if (req_data.size == '0 ||
                req_data.align_log2 > sarena_pkg::ALIGN_W'(sarena_pkg::MAX_ALIGN))
               cmd_new.kind = sarena_pkg::CMD_BAD;
            else
               cmd_new.kind = sarena_pkg::CMD_ALLOC;
         end
         sarena_pkg::REQ_FREE: begin
            cmd_new.kind = sarena_pkg::CMD_FREE;
         end
         default: begin
            // resize and unused codes
            cmd_new.kind = sarena_pkg::CMD_BAD;
         end
      endcase
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== sv/sarena_stack.sv =====
// Order-check stack: end offsets of live blocks, with top and second entries held in registers.
module sarena_stack (
   input  logic                      clock,
   input  logic                      reset,
   input  sarena_pkg::stk_ctl_type   stk_ctl,
   output sarena_pkg::stk_stat_type  stk_stat
);

   logic [sarena_pkg::ADDR_W-1:0]    mem_ff [sarena_pkg::MAX_TRACKED];
   logic [sarena_pkg::ADDR_W-1:0]    rd_data_ff;
   logic [sarena_pkg::STK_CNT_W-1:0] count_ff, count_in;
   logic [sarena_pkg::STK_CNT_W-1:0] rd_idx;
   logic [sarena_pkg::ADDR_W-1:0]    tos_ff, tos_in;
   logic [sarena_pkg::ADDR_W-1:0]    exp_ff, exp_in;
   logic                             refill_ff, refill_in;
   logic                             need_refill;

   // after a pop the new second entry sits in memory: fetch it the next cycle
   assign need_refill = count_ff >= sarena_pkg::STK_CNT_W'(3);
   assign rd_idx      = count_ff - sarena_pkg::STK_CNT_W'(3);

   always_comb begin
      count_in  = count_ff;
      tos_in    = tos_ff;
      exp_in    = exp_ff;
      refill_in = 1'b0;
      if (refill_ff) begin
         exp_in = rd_data_ff;
      end else if (stk_ctl.push) begin
         exp_in   = (count_ff == '0) ? '0 : tos_ff;
         tos_in   = stk_ctl.push_data;
         count_in = count_ff + sarena_pkg::STK_CNT_W'(1);
      end else if (stk_ctl.pop) begin
         tos_in   = exp_ff;
         count_in = count_ff - sarena_pkg::STK_CNT_W'(1);
         if (need_refill)
            refill_in = 1'b1;
         else
            exp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         refill_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         refill_ff <= refill_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      exp_ff <= exp_in;
   end

   always_ff @(posedge clock) begin
      if (stk_ctl.push) begin
         mem_ff[count_ff[sarena_pkg::STK_IDX_W-1:0]] <= stk_ctl.push_data;
      end
      if (stk_ctl.pop && need_refill) begin
         rd_data_ff <= mem_ff[rd_idx[sarena_pkg::STK_IDX_W-1:0]];
      end
   end

   assign stk_stat.count   = count_ff;
   assign stk_stat.exp_off = exp_ff;

   a_refill_quiet: assert property (@(posedge clock) disable iff (reset)
      refill_ff |-> !stk_ctl.push && !stk_ctl.pop)
      else $error("stack operation during refill");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      stk_ctl.push |-> count_ff < sarena_pkg::STK_CNT_W'(sarena_pkg::MAX_TRACKED))
      else $error("stack push when full");

   a_pop_live: assert property (@(posedge clock) disable iff (reset)
      stk_ctl.pop |-> count_ff != '0 && !stk_ctl.push)
      else $error("stack pop when empty or with push");

endmodule

// ===== sv/sarena_back.sv =====
// Execution: config registers, top/peak state, two-step alloc/free evaluation, result queue.
module sarena_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sarena_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sarena_pkg::ADDR_W-1:0]       csr_wdata,
   input  logic                                cmd_valid,
   input  sarena_pkg::cmd_word_type            cmd_data,
   output logic                                cmd_pop,
   output sarena_pkg::stk_ctl_type             stk_ctl,
   input  sarena_pkg::stk_stat_type            stk_stat,
   output logic                                empty,
   input  logic                                pop,
   output sarena_pkg::rsp_word_type            rsp_data
);

   localparam int AW = sarena_pkg::ADDR_W;

   logic [AW-1:0]                  base_ff, base_in;
   logic [AW-1:0]                  cap_ff, cap_in;
   logic [sarena_pkg::TRACK_W-1:0] track_ff, track_in;
   logic [AW-1:0]                  top_ff, top_in;
   logic [AW-1:0]                  peak_ff, peak_in;
   sarena_pkg::bk_state_type       state_ff, state_in;

   // evaluation stage
   sarena_pkg::cmd_kind_type kind_ff;
   logic [AW+1:0]            start_ff;
   logic [AW:0]              asize_ff;
   logic                     outside_ff, above_ff;
   logic [AW-1:0]            off_ff;

   logic [AW+1:0] sum1, amask_w, start_c;
   logic [AW:0]   lim;
   logic          outside_c, above_c;
   logic          ld_stage, commit;

   logic [AW+2:0]                    end_c;
   logic [AW-1:0]                    newtop;
   logic                             track_on, trk_full;
   sarena_pkg::status_type           st;
   logic [AW-1:0]                    res_addr;
   logic                             upd_top;
   logic [AW-1:0]                    top_val, peak_val;
   logic [sarena_pkg::STK_CNT_W-1:0] cnt_after;
   sarena_pkg::rsp_word_type         rsp_new;

   sarena_pkg::rsp_word_type oq_ff [2];
   logic                     oq_wr_ff, oq_rd_ff;
   logic [1:0]               oq_cnt_ff, oq_cnt_in;
   logic                     oq_full, oq_pop;

   // configuration
   always_comb begin
      base_in  = base_ff;
      cap_in   = cap_ff;
      track_in = track_ff;
      if (csr_wr_en) begin
         case (csr_index)
            sarena_pkg::CSR_BASE_ADDR:   base_in  = csr_wdata;
            sarena_pkg::CSR_CAPACITY:    cap_in   = csr_wdata;
            sarena_pkg::CSR_TRACK_LIMIT: track_in = csr_wdata[sarena_pkg::TRACK_W-1:0];
            default: ;
         endcase
      end
   end

   // first step: aligned start, free range checks
   always_comb begin
      amask_w   = (AW + 2)'(cmd_data.amask);
      sum1      = (AW + 2)'(base_ff) + (AW + 2)'(top_ff) + amask_w;
      start_c   = sum1 & ~amask_w;
      lim       = (AW + 1)'(base_ff) + (AW + 1)'(cap_ff);
      outside_c = (cmd_data.addr < base_ff) || ((AW + 1)'(cmd_data.addr) >= lim);
      above_c   = (AW + 1)'(cmd_data.addr) >= ((AW + 1)'(base_ff) + (AW + 1)'(top_ff));
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      ld_stage = 1'b0;
      commit   = 1'b0;
      case (state_ff)
         sarena_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               ld_stage = 1'b1;
               state_in = sarena_pkg::BK_COMMIT;
            end
         end
         sarena_pkg::BK_COMMIT: begin
            if (!oq_full) begin
               commit   = 1'b1;
               state_in = sarena_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = sarena_pkg::BK_IDLE;
         end
      endcase
   end

   // second step: space/order checks and state update
   always_comb begin
      track_on = track_ff != '0;
      trk_full = (int'(stk_stat.count) >= int'(track_ff)) ||
                 (int'(stk_stat.count) >= sarena_pkg::MAX_TRACKED);
      end_c    = (AW + 3)'(start_ff) + (AW + 3)'(asize_ff);
      newtop   = end_c[AW-1:0] - base_ff;

      st                = sarena_pkg::ST_BAD_REQ;
      res_addr          = '0;
      upd_top           = 1'b0;
      top_val           = top_ff;
      peak_val          = peak_ff;
      stk_ctl.push      = 1'b0;
      stk_ctl.pop       = 1'b0;
      stk_ctl.push_data = newtop;

      case (kind_ff)
         sarena_pkg::CMD_ALLOC: begin
            if (end_c > (AW + 3)'(lim) || end_c > sarena_pkg::ADDR_SPAN) begin
               st = sarena_pkg::ST_NO_SPACE;
            end else if (track_on && trk_full) begin
               st = sarena_pkg::ST_TRACK_FULL;
            end else begin
               st           = sarena_pkg::ST_OK;
               res_addr     = start_ff[AW-1:0];
               upd_top      = 1'b1;
               top_val      = newtop;
               if (newtop > peak_ff)
                  peak_val = newtop;
               stk_ctl.push = commit && track_on;
            end
         end
         sarena_pkg::CMD_FREE: begin
            if (outside_ff) begin
               st = sarena_pkg::ST_OUTSIDE;
            end else if (above_ff) begin
               st = sarena_pkg::ST_ABOVE_TOP;
            end else if (track_on &&
                         (stk_stat.count == '0 || off_ff != stk_stat.exp_off)) begin
               st = sarena_pkg::ST_ORDER;
            end else begin
               st          = sarena_pkg::ST_OK;
               upd_top     = 1'b1;
               top_val     = off_ff;
               stk_ctl.pop = commit && track_on;
            end
         end
         default: begin
            st = sarena_pkg::ST_BAD_REQ;
         end
      endcase

      cnt_after = stk_stat.count + sarena_pkg::STK_CNT_W'(stk_ctl.push)
                  - sarena_pkg::STK_CNT_W'(stk_ctl.pop);

      rsp_new.status      = st;
      rsp_new.result_addr = res_addr;
      rsp_new.used_bytes  = top_val;
      rsp_new.peak_bytes  = peak_val;
      rsp_new.live_count  = sarena_pkg::LIVE_W'(cnt_after);

      top_in  = (commit && upd_top) ? top_val : top_ff;
      peak_in = commit ? peak_val : peak_ff;
   end

   // result queue
   assign oq_full  = (oq_cnt_ff == 2'd2);
   assign empty    = (oq_cnt_ff == 2'd0);
   assign oq_pop   = pop && !empty;
   assign rsp_data = oq_ff[oq_rd_ff];
   assign oq_cnt_in = oq_cnt_ff + 2'(commit) - 2'(oq_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         cap_ff    <= '0;
         track_ff  <= '0;
         top_ff    <= '0;
         peak_ff   <= '0;
         state_ff  <= sarena_pkg::BK_IDLE;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         base_ff   <= base_in;
         cap_ff    <= cap_in;
         track_ff  <= track_in;
         top_ff    <= top_in;
         peak_ff   <= peak_in;
         state_ff  <= state_in;
         oq_wr_ff  <= oq_wr_ff ^ commit;
         oq_rd_ff  <= oq_rd_ff ^ oq_pop;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_stage) begin
         kind_ff    <= cmd_data.kind;
         start_ff   <= start_c;
         asize_ff   <= cmd_data.asize;
         outside_ff <= outside_c;
         above_ff   <= above_c;
         off_ff     <= cmd_data.addr - base_ff;
      end
      if (commit) begin
         oq_ff[oq_wr_ff] <= rsp_new;
      end
   end

   a_peak_covers_top: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= top_ff)
      else $error("peak below top offset");

   a_stack_needs_track: assert property (@(posedge clock) disable iff (reset)
      (stk_ctl.push || stk_ctl.pop) |-> commit && track_on)
      else $error("stack touched outside a tracked commit");

   a_top_moves_on_commit: assert property (@(posedge clock) disable iff (reset)
      !commit |=> top_ff == $past(top_ff))
      else $error("top offset changed without a commit");

endmodule

// ===== sv/stack_arena_allocator.sv =====
// Top level of the LIFO arena allocator: intake, execution and order-check stack.
// A pushed word passes the command queue and the evaluation stage, then reaches rsp_data
// (empty low) on commit. The back-end sequencer takes a new command once the last commits.
// The front queue keeps accepting while a result waits in the two-entry result queue.
// Reset (synchronous, active high) clears config, top/peak offsets, live count and queues;
// the stack memory is not cleared since only entries below the live count are read.
module stack_arena_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  sarena_pkg::req_word_type          req_data,
   output logic                              empty,
   input  logic                              pop,
   output sarena_pkg::rsp_word_type          rsp_data,
   input  logic                              csr_wr_en,
   input  logic [sarena_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sarena_pkg::ADDR_W-1:0]     csr_wdata
);

   logic                     cmd_valid;
   logic                     cmd_pop;
   sarena_pkg::cmd_word_type cmd_data;
   sarena_pkg::stk_ctl_type  stk_ctl;
   sarena_pkg::stk_stat_type stk_stat;

   sarena_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   sarena_stack u_stack (
      .clock    (clock),
      .reset    (reset),
      .stk_ctl  (stk_ctl),
      .stk_stat (stk_stat)
   );

   sarena_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .stk_ctl   (stk_ctl),
      .stk_stat  (stk_stat),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
